// ===== rtl/text_console_cursor_scroll_top_defines.svh =====
// assertion macros shared by the checker
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_DEFINES_SVH

// same-cycle implication, gated off while rst_n is low
`define TCCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("console check failed");

// next-cycle implication, gated off while rst_n is low
`define TCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("console check failed");

`endif

// ===== rtl/tccs_pkg.sv =====
`default_nettype none

package tccs_pkg;

    localparam int COLS_DEFAULT = 80;
    localparam int ROWS_DEFAULT = 25;

    localparam int OPCODE_W    = 2;
    localparam int CHAR_W      = 8;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int CELL_W      = 2 * CHAR_W;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] BLANK_ATTR   = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_ATTR, BLANK_CHAR};

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        S_FILL,
        S_IDLE,
        S_READ
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/text_console_cursor_scroll_top.sv =====
`default_nettype none
// text console: put, read, clear; clear and a put that scrolls stay busy while the fill
// sweep writes one blank cell per cycle (every cell, or the old top row), an in-range read
// while its cell is fetched; strobe the cycle after accept, for an in-range read after its
// busy cycle; the receiver cannot stall; rows sit in the cell memory as a ring, so a scroll
// only blanks the old top row; synchronous active-low reset homes the cursor and starts a
// clearing pass over all ROWS*COLS cells, busy stays high until it is done

module text_console_cursor_scroll_top #(
    parameter int COLS = tccs_pkg::COLS_DEFAULT,
    parameter int ROWS = tccs_pkg::ROWS_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [tccs_pkg::OPCODE_W-1:0]       i_opcode,
    input  wire logic [tccs_pkg::CHAR_W-1:0]         i_char_code,
    input  wire logic [tccs_pkg::CHAR_W-1:0]         i_attribute,
    input  wire logic [tccs_pkg::ROW_FIELD_W-1:0]    i_read_row,
    input  wire logic [tccs_pkg::COL_FIELD_W-1:0]    i_read_col,
    output logic                                     o_result_strobe,
    output logic [tccs_pkg::CHAR_W-1:0]              o_cell_char,
    output logic [tccs_pkg::CHAR_W-1:0]              o_cell_attribute,
    output logic [tccs_pkg::ROW_FIELD_W-1:0]         o_cursor_row,
    output logic [tccs_pkg::COL_FIELD_W-1:0]         o_cursor_col
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int RF_W   = tccs_pkg::ROW_FIELD_W;
    localparam int CF_W   = tccs_pkg::COL_FIELD_W;
    localparam int CELL_W = tccs_pkg::CELL_W;

    // cell memory: one write port, one registered read port
    logic [CELL_W-1:0] mem [CELLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] r_rdata;

    // control state
    tccs_pkg::t_state  r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;      // cursor row, logical
    logic [COL_W-1:0]  r_col, n_col;      // cursor column
    logic [ROW_W-1:0]  r_base, n_base;    // physical row that shows as logical row 0
    logic [ADDR_W-1:0] r_addr, n_addr;    // fill sweep pointer
    logic [ADDR_W-1:0] r_last, n_last;    // last address of the fill sweep
    logic              r_strobe, n_strobe;
    logic [CELL_W-1:0] r_cell, n_cell;

    // read request decode
    logic [ROW_W+RF_W-1:0] rd_row_ext;
    logic [COL_W+CF_W-1:0] rd_col_ext;
    logic                  rd_in_range;
    logic [ROW_W-1:0]      rd_row;
    logic [COL_W-1:0]      rd_col;

    // put decode
    logic                  is_newline;
    logic                  line_wrap;
    logic                  at_last_row;
    logic [ROW_W-1:0]      base_inc;
    logic [ADDR_W-1:0]     top_row_addr;

    // output resize
    logic [ROW_W+RF_W-1:0] cur_row_ext;
    logic [COL_W+CF_W-1:0] cur_col_ext;

    // logical row to physical row in the ring
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, base};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // first cell address of a physical row
    function automatic logic [ADDR_W-1:0] row_addr(input logic [ROW_W-1:0] prow);
        return ADDR_W'(prow) * ADDR_W'(COLS);
    endfunction

    assign rd_row_ext  = {ROW_W'(0), i_read_row};
    assign rd_col_ext  = {COL_W'(0), i_read_col};
    assign rd_in_range = (rd_row_ext < (ROW_W+RF_W)'(ROWS)) &&
                         (rd_col_ext < (COL_W+CF_W)'(COLS));
    assign rd_row      = rd_row_ext[ROW_W-1:0];
    assign rd_col      = rd_col_ext[COL_W-1:0];

    assign is_newline   = (i_char_code == tccs_pkg::NEWLINE_CODE);
    assign line_wrap    = is_newline || (r_col == COL_W'(COLS - 1));
    assign at_last_row  = (r_row == ROW_W'(ROWS - 1));
    assign base_inc     = (r_base == ROW_W'(ROWS - 1)) ? '0 : r_base + 1'b1;
    // after a scroll the old top row becomes the new bottom row
    assign top_row_addr = row_addr(r_base);

    assign busy = (r_state != tccs_pkg::S_IDLE);

    // next state, memory port control and result
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_base    = r_base;
        n_addr    = r_addr;
        n_last    = r_last;
        n_strobe  = 1'b0;
        n_cell    = '0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = tccs_pkg::BLANK_CELL;
        mem_raddr = row_addr(phys_row(rd_row, r_base)) + ADDR_W'(rd_col);

        unique case (r_state)
            tccs_pkg::S_FILL: begin
                // one blank cell per cycle
                mem_we = 1'b1;
                if (r_addr == r_last) begin
                    n_state = tccs_pkg::S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            tccs_pkg::S_READ: begin
                // read data of the cell is in r_rdata now
                n_cell   = r_rdata;
                n_strobe = 1'b1;
                n_state  = tccs_pkg::S_IDLE;
            end
            tccs_pkg::S_IDLE: begin
                if (start) begin
                    unique case (tccs_pkg::t_opcode'(i_opcode))
                        tccs_pkg::OP_PUT: begin
                            n_strobe = 1'b1;
                            if (!is_newline) begin
                                mem_we    = 1'b1;
                                mem_waddr = row_addr(phys_row(r_row, r_base)) +
                                            ADDR_W'(r_col);
                                mem_wdata = {i_attribute, i_char_code};
                                n_col     = r_col + 1'b1;
                            end
                            if (line_wrap) begin
                                n_col = '0;
                                if (at_last_row) begin
                                    // scroll: rotate the ring, blank the new bottom row
                                    n_base  = base_inc;
                                    n_addr  = top_row_addr;
                                    n_last  = top_row_addr + ADDR_W'(COLS - 1);
                                    n_state = tccs_pkg::S_FILL;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end
                        end
                        tccs_pkg::OP_CLEAR: begin
                            n_strobe = 1'b1;
                            n_row    = '0;
                            n_col    = '0;
                            n_base   = '0;
                            n_addr   = '0;
                            n_last   = ADDR_W'(CELLS - 1);
                            n_state  = tccs_pkg::S_FILL;
                        end
                        tccs_pkg::OP_READ: begin
                            if (rd_in_range) begin
                                n_state = tccs_pkg::S_READ;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        default: begin
                            // unused opcode only reports the cursor
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tccs_pkg::S_FILL;
            r_row    <= '0;
            r_col    <= '0;
            r_base   <= '0;
            r_addr   <= '0;
            r_last   <= ADDR_W'(CELLS - 1);
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_base   <= n_base;
            r_addr   <= n_addr;
            r_last   <= n_last;
            r_strobe <= n_strobe;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    // cell memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // cursor holds its post-item value through the strobe cycle
    assign cur_row_ext = {RF_W'(0), r_row};
    assign cur_col_ext = {CF_W'(0), r_col};

    assign o_result_strobe  = r_strobe;
    assign o_cell_char      = r_cell[tccs_pkg::CHAR_W-1:0];
    assign o_cell_attribute = r_cell[CELL_W-1:tccs_pkg::CHAR_W];
    assign o_cursor_row     = cur_row_ext[RF_W-1:0];
    assign o_cursor_col     = cur_col_ext[CF_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/tccs_checker.sv =====
`default_nettype none
`include "text_console_cursor_scroll_top_defines.svh"

module tccs_checker #(
    parameter int COLS = tccs_pkg::COLS_DEFAULT,
    parameter int ROWS = tccs_pkg::ROWS_DEFAULT
) (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic                             o_result_strobe,
    input wire logic [tccs_pkg::CHAR_W-1:0]      o_cell_char,
    input wire logic [tccs_pkg::CHAR_W-1:0]      o_cell_attribute,
    input wire logic [tccs_pkg::ROW_FIELD_W-1:0] o_cursor_row,
    input wire logic [tccs_pkg::COL_FIELD_W-1:0] o_cursor_col
);

    logic accept;
    logic cell_nonzero;

    assign accept       = start && !busy;
    assign cell_nonzero = (o_cell_char != '0) || (o_cell_attribute != '0);

    // reset always starts the clearing pass
    `TCCS_ASSERT_NEXT(a_reset_clears, i_clk, 1'b1, !i_rst_n, busy && !o_result_strobe)

    // an item either reports next cycle or keeps the block busy
    `TCCS_ASSERT_NEXT(a_item_progress, i_clk, i_rst_n, accept, o_result_strobe || busy)

    // cursor reported stays on screen
    `TCCS_ASSERT_NOW(a_cursor_on_screen, i_clk, i_rst_n, o_result_strobe, (32'(o_cursor_row) < ROWS) && (32'(o_cursor_col) < COLS))

    // cell data only comes from an in-range read, which is busy while its cell is fetched
    `TCCS_ASSERT_NOW(a_cell_from_read, i_clk, i_rst_n, o_result_strobe && cell_nonzero, $past(busy))

endmodule

bind text_console_cursor_scroll_top tccs_checker #(
    .COLS(COLS),
    .ROWS(ROWS)
) u_tccs_checker (.*);

`default_nettype wire
